### sv/esc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// esc_pkg
// Shared types, register codes and pipeline constants of the environmental
// sensor compensation core.
// ----------------------------------------------------------------------------
package esc_pkg;

  typedef struct packed {
    logic [19:0] raw_temperature;
    logic [19:0] raw_pressure;
    logic [15:0] raw_humidity;
  } sample_t;

  typedef struct packed {
    logic signed [31:0] temperature_centideg;
    logic [31:0]        pressure_q24_8;
    logic [16:0]        humidity_q22_10;
    logic               pressure_invalid;
  } result_t;

  typedef struct packed {
    logic signed [31:0] tc;
    logic [16:0]        hum;
    logic               zero;
  } side_t;

  localparam logic [2:0] CFG_TEMP_TRIM       = 3'd0;
  localparam logic [2:0] CFG_PRESS_TRIM_LOW  = 3'd1;
  localparam logic [2:0] CFG_PRESS_TRIM_HIGH = 3'd2;
  localparam logic [2:0] CFG_HUM_TRIM_A      = 3'd3;
  localparam logic [2:0] CFG_HUM_TRIM_B      = 3'd4;

  localparam int DIV_BITS   = 64;
  localparam int DVS_W      = 31;
  localparam int RAW_DEPTH  = 11;
  localparam int TC_DEPTH   = 9;
  localparam int SIDE_DEPTH = 71;
  localparam int OUT_STAGE  = 85;
  localparam int LATENCY    = OUT_STAGE + 1;

  function automatic logic signed [31:0] sx32(input logic [15:0] f);
    return {{16{f[15]}}, f};
  endfunction

  function automatic logic [63:0] sx64(input logic [15:0] f);
    return {{48{f[15]}}, f};
  endfunction

endpackage
`default_nettype wire

### sv/esc_mul64.sv
`default_nettype none
// ----------------------------------------------------------------------------
// esc_mul64
// Two-stage 64 x 64 multiplier giving the low 64 bits of the product.
// ----------------------------------------------------------------------------
module esc_mul64 (
  input  logic        clk,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic [63:0] y
);
  logic [63:0] ll;
  logic [31:0] lh;
  logic [31:0] hl;

  always_ff @(posedge clk) begin
    ll <= a[31:0] * b[31:0];
    lh <= a[31:0] * b[63:32];
    hl <= a[63:32] * b[31:0];
    y  <= ll + {lh + hl, 32'd0};
  end
endmodule
`default_nettype wire

### sv/esc_sdiv.sv
`default_nettype none
// ----------------------------------------------------------------------------
// esc_sdiv
// Pipelined signed divider, 64-bit dividend by 31-bit divisor, one quotient
// bit per stage, truncating toward zero.
// ----------------------------------------------------------------------------
module esc_sdiv (
  input  logic        clk,
  input  logic [63:0] dividend,
  input  logic [esc_pkg::DVS_W-1:0] divisor,
  output logic [63:0] quotient
);
  import esc_pkg::*;

  logic [DVS_W-1:0] rem [0:DIV_BITS];
  logic [63:0]      wrk [0:DIV_BITS];
  logic [DVS_W-1:0] mb  [0:DIV_BITS];
  logic             neg [0:DIV_BITS];

  always_ff @(posedge clk) begin
    rem[0] <= '0;
    wrk[0] <= dividend[63] ? (64'd0 - dividend) : dividend;
    mb[0]  <= divisor[DVS_W-1] ? (DVS_W'(0) - divisor) : divisor;
    neg[0] <= dividend[63] ^ divisor[DVS_W-1];
  end

  for (genvar i = 0; i < DIV_BITS; i++) begin : g_step
    logic [DVS_W:0] t;
    logic [DVS_W:0] d;
    logic           ge;
    assign t  = {rem[i], wrk[i][63]};
    assign ge = t >= {1'b0, mb[i]};
    assign d  = t - {1'b0, mb[i]};
    always_ff @(posedge clk) begin
      rem[i+1] <= ge ? d[DVS_W-1:0] : t[DVS_W-1:0];
      wrk[i+1] <= {wrk[i][62:0], ge};
      mb[i+1]  <= mb[i];
      neg[i+1] <= neg[i];
    end
  end

  always_ff @(posedge clk) begin
    quotient <= neg[DIV_BITS] ? (64'd0 - wrk[DIV_BITS]) : wrk[DIV_BITS];
  end
endmodule
`default_nettype wire

### sv/env_sensor_compensation_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// env_sensor_compensation_core
// Integer compensation of raw temperature, pressure and humidity codes.
// Done is the accepted start carried down a valid shift register as deep as the data path, set by the 64-stage divider.
// Throughput: one word per cycle; busy stays low, results cannot be stalled.
// Reset clears the valid pipeline and all trim registers to zero.
// ----------------------------------------------------------------------------
module env_sensor_compensation_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  esc_pkg::sample_t sample,
  output logic             done,
  output esc_pkg::result_t result,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [2:0]       cfg_index,
  input  logic [63:0]      cfg_data
);
  import esc_pkg::*;

  logic [47:0] temp_trim;
  logic [63:0] press_trim_low;
  logic [63:0] press_trim_high;
  logic [47:0] hum_trim_a;
  logic [39:0] hum_trim_b;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_trim       <= '0;
      press_trim_low  <= '0;
      press_trim_high <= '0;
      hum_trim_a      <= '0;
      hum_trim_b      <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_TEMP_TRIM:       temp_trim       <= cfg_data[47:0];
        CFG_PRESS_TRIM_LOW:  press_trim_low  <= cfg_data;
        CFG_PRESS_TRIM_HIGH: press_trim_high <= cfg_data;
        CFG_HUM_TRIM_A:      hum_trim_a      <= cfg_data[47:0];
        CFG_HUM_TRIM_B:      hum_trim_b      <= cfg_data[39:0];
        default: ;
      endcase
    end
  end

  logic signed [31:0] t1, t2, t3, h1, h2, h3, h4, h5, h6;
  logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;

  assign t1 = {16'd0, temp_trim[15:0]};
  assign t2 = sx32(temp_trim[31:16]);
  assign t3 = sx32(temp_trim[47:32]);
  assign h1 = {24'd0, hum_trim_a[23:16]};
  assign h2 = sx32(hum_trim_a[39:24]);
  assign h3 = {24'd0, hum_trim_a[47:40]};
  assign h4 = sx32(hum_trim_b[15:0]);
  assign h5 = sx32(hum_trim_b[31:16]);
  assign h6 = {{24{hum_trim_b[39]}}, hum_trim_b[39:32]};
  assign p1 = {48'd0, press_trim_low[15:0]};
  assign p2 = sx64(press_trim_low[31:16]);
  assign p3 = sx64(press_trim_low[47:32]);
  assign p4 = sx64(press_trim_low[63:48]);
  assign p5 = sx64(press_trim_high[15:0]);
  assign p6 = sx64(press_trim_high[31:16]);
  assign p7 = sx64(press_trim_high[47:32]);
  assign p8 = sx64(press_trim_high[63:48]);
  assign p9 = sx64(hum_trim_a[15:0]);

  logic [OUT_STAGE:0] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[OUT_STAGE-1:0], start & ~busy};
    end
  end

  sample_t raw [0:RAW_DEPTH-1];

  always_ff @(posedge clk) begin
    raw[0] <= sample;
    for (int i = 1; i < RAW_DEPTH; i++) begin
      raw[i] <= raw[i-1];
    end
  end

  // temperature
  logic signed [31:0] ta, td, tam, tdd, ta_s, bsq, tf, tf5;
  logic signed [31:0] tc_pipe [0:TC_DEPTH-1];
  logic signed [31:0] hv;
  logic [63:0]        v1;

  assign tf5 = (tf <<< 2) + tf + 32'sd128;

  always_ff @(posedge clk) begin
    ta   <= $signed({15'd0, raw[0].raw_temperature[19:3]}) - $signed({15'd0, t1[15:0], 1'b0});
    td   <= $signed({16'd0, raw[0].raw_temperature[19:4]}) - t1;
    tam  <= ta * t2;
    tdd  <= td * td;
    ta_s <= tam >>> 11;
    bsq  <= (tdd >>> 12) * t3;
    tf   <= ta_s + (bsq >>> 14);
    tc_pipe[0] <= tf5 >>> 8;
    v1   <= {{32{tf[31]}}, tf} - 64'd128000;
    hv   <= tf - 32'sd76800;
    for (int i = 1; i < TC_DEPTH; i++) begin
      tc_pipe[i] <= tc_pipe[i-1];
    end
  end

  // humidity
  logic signed [31:0] m_h5, m_h6, m_h3, x1, x1_d1, x1_d2, hu, hw, uw, hy, x1x2;
  logic signed [31:0] hval, hval_d, qq, hr, x1_sum, hv2, vf;
  logic [16:0]        hum;

  assign x1_sum = $signed({2'b0, raw[6].raw_humidity, 14'd0}) - $signed({h4[11:0], 20'd0})
                  - m_h5 + 32'sd16384;
  assign hv2    = x1x2 >>> 14;
  assign vf     = hval_d - (hr >>> 4);

  always_comb begin
    priority if (vf < 0) begin
      hum = '0;
    end else if (vf > 32'sd419430400) begin
      hum = 17'd102400;
    end else begin
      hum = vf[28:12];
    end
  end

  always_ff @(posedge clk) begin
    m_h5   <= h5 * hv;
    m_h6   <= hv * h6;
    m_h3   <= hv * h3;
    x1     <= x1_sum >>> 15;
    hu     <= m_h6 >>> 10;
    hw     <= (m_h3 >>> 11) + 32'sd32768;
    uw     <= hu * hw;
    x1_d1  <= x1;
    hy     <= ((uw >>> 10) + 32'sd2097152) * h2;
    x1_d2  <= x1_d1;
    x1x2   <= x1_d2 * (hy + 32'sd8192);
    hval   <= hv2;
    qq     <= (hv2 >>> 15) * (hv2 >>> 15);
    hr     <= (qq >>> 7) * h1;
    hval_d <= hval;
  end

  // pressure
  logic [63:0] v1sq, mp5, mp2, m6, m3, mp5_d [0:1], mp2_d [0:1];
  logic [63:0] v2, x1e, x1e_d, num, m3125, mp1;
  logic [20:0] pdiff;

  assign pdiff = 21'd1048576 - {1'b0, raw[10].raw_pressure};

  esc_mul64 u_mul_v1sq (.clk(clk), .a(v1),   .b(v1), .y(v1sq));
  esc_mul64 u_mul_p5   (.clk(clk), .a(v1),   .b(p5), .y(mp5));
  esc_mul64 u_mul_p2   (.clk(clk), .a(v1),   .b(p2), .y(mp2));
  esc_mul64 u_mul_p6   (.clk(clk), .a(v1sq), .b(p6), .y(m6));
  esc_mul64 u_mul_p3   (.clk(clk), .a(v1sq), .b(p3), .y(m3));

  always_ff @(posedge clk) begin
    mp5_d[0] <= mp5;
    mp5_d[1] <= mp5_d[0];
    mp2_d[0] <= mp2;
    mp2_d[1] <= mp2_d[0];
    v2       <= m6 + (mp5_d[1] << 17) + (p4 << 35);
    x1e      <= 64'($signed(m3) >>> 8) + (mp2_d[1] << 12) + 64'h0000_8000_0000_0000;
    num      <= ({43'd0, pdiff} << 31) - v2;
    x1e_d    <= x1e;
  end

  esc_mul64 u_mul_k    (.clk(clk), .a(num),   .b(64'd3125), .y(m3125));
  esc_mul64 u_mul_p1   (.clk(clk), .a(x1e_d), .b(p1),       .y(mp1));

  logic [63:0] pq, ps, pd [0:3], m9s, m8p, mg_d [0:1], mh, sumv;

  esc_sdiv u_div (
    .clk      (clk),
    .dividend (m3125),
    .divisor  (mp1[63:33]),
    .quotient (pq)
  );

  assign ps = 64'($signed(pq) >>> 13);

  esc_mul64 u_mul_p9 (.clk(clk), .a(p9),  .b(ps), .y(m9s));
  esc_mul64 u_mul_p8 (.clk(clk), .a(p8),  .b(pq), .y(m8p));
  esc_mul64 u_mul_ss (.clk(clk), .a(m9s), .b(64'($signed(pd[1]) >>> 13)), .y(mh));

  always_ff @(posedge clk) begin
    pd[0]   <= pq;
    pd[1]   <= pd[0];
    pd[2]   <= pd[1];
    pd[3]   <= pd[2];
    mg_d[0] <= m8p;
    mg_d[1] <= mg_d[0];
    sumv    <= pd[3] + 64'($signed(mh) >>> 25) + 64'($signed(mg_d[1]) >>> 19);
  end

  // side band and output
  side_t side [0:SIDE_DEPTH-1];
  logic [63:0] sum_s;
  logic [16:0] hum_q;

  assign sum_s = 64'($signed(sumv) >>> 8);

  always_ff @(posedge clk) begin
    hum_q        <= hum;
    side[0].tc   <= tc_pipe[TC_DEPTH-1];
    side[0].hum  <= hum_q;
    side[0].zero <= (mp1[63:33] == '0);
    for (int i = 1; i < SIDE_DEPTH; i++) begin
      side[i] <= side[i-1];
    end
    result.temperature_centideg <= side[SIDE_DEPTH-1].tc;
    result.humidity_q22_10      <= side[SIDE_DEPTH-1].hum;
    result.pressure_invalid     <= side[SIDE_DEPTH-1].zero;
    result.pressure_q24_8       <= side[SIDE_DEPTH-1].zero ? 32'd0
                                   : sum_s[31:0] + {p7[27:0], 4'd0};
  end

  assign done = vld[OUT_STAGE];

  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LATENCY done)
    else $error("accepted word did not reach the output on time");

  a_hum_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.humidity_q22_10 <= 17'd102400))
    else $error("humidity above clamp");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result.pressure_invalid) |-> (result.pressure_q24_8 == 32'd0))
    else $error("invalid pressure not forced to zero");

endmodule
`default_nettype wire
